[rtl/tse_pkg.sv]
`default_nettype none

package tse_pkg;

	// Field and port widths
	localparam int unsigned CHAR_W          = 8;
	localparam int unsigned YEAR_W          = 14;
	localparam int unsigned FIELD_W         = 7;
	localparam int unsigned EPOCH_W         = 64;
	localparam int unsigned ERR_W           = 2;
	localparam int unsigned OUT_TDATA_W     = 72;
	localparam int unsigned POS_W           = 5;
	localparam int unsigned POW10_W         = 30;
	localparam int unsigned FRAC_DIGITS_DEF = 6;

	// Error codes on the result
	localparam logic [ERR_W-1:0] ERR_NONE      = 2'd0;
	localparam logic [ERR_W-1:0] ERR_DATE_TIME = 2'd1;
	localparam logic [ERR_W-1:0] ERR_OFFSET    = 2'd2;

	// ASCII codes
	localparam logic [CHAR_W-1:0] CH_TAB   = 8'h09;
	localparam logic [CHAR_W-1:0] CH_LF    = 8'h0A;
	localparam logic [CHAR_W-1:0] CH_CR    = 8'h0D;
	localparam logic [CHAR_W-1:0] CH_SPACE = 8'h20;
	localparam logic [CHAR_W-1:0] CH_PLUS  = 8'h2B;
	localparam logic [CHAR_W-1:0] CH_DASH  = 8'h2D;
	localparam logic [CHAR_W-1:0] CH_DOT   = 8'h2E;
	localparam logic [CHAR_W-1:0] CH_0     = 8'h30;
	localparam logic [CHAR_W-1:0] CH_9     = 8'h39;
	localparam logic [CHAR_W-1:0] CH_COLON = 8'h3A;
	localparam logic [CHAR_W-1:0] CH_T_UP  = 8'h54;
	localparam logic [CHAR_W-1:0] CH_T_LO  = 8'h74;

	typedef enum logic [4:0] {
		ST_START,
		ST_FIXED,
		ST_AFTER_SEC,
		ST_FRAC,
		ST_OFF_H1,
		ST_OFF_H2,
		ST_OFF_COLON,
		ST_OFF_M1,
		ST_OFF_M2,
		ST_DONE,
		ST_ERR_DT,
		ST_ERR_OFF,
		ST_CV1,
		ST_CV2,
		ST_CV3,
		ST_CV4,
		ST_CV5,
		ST_CV6,
		ST_CV7,
		ST_EMIT
	} state_t;

	typedef enum logic [3:0] {
		ACC_NONE,
		ACC_YEAR,
		ACC_MONTH,
		ACC_DAY,
		ACC_HOUR,
		ACC_MIN,
		ACC_SEC,
		ACC_FRAC,
		ACC_OFF_H,
		ACC_OFF_M
	} acc_sel_t;

	typedef enum logic [2:0] {
		CV_IDLE,
		CV_1,
		CV_2,
		CV_3,
		CV_4,
		CV_5,
		CV_6,
		CV_7
	} cv_step_t;

	typedef enum logic [1:0] {
		OUT_EPOCH,
		OUT_BLANK,
		OUT_ERR_DT,
		OUT_ERR_OFF
	} out_kind_t;

	// Controller to datapath
	typedef struct packed {
		acc_sel_t  acc_sel;
		logic      set_sign;
		logic      sign_neg;
		logic      clear;
		cv_step_t  cv_step;
		logic      load_out;
		out_kind_t out_kind;
	} cmd_t;

	// Datapath to controller
	typedef struct packed {
		logic is_digit;
		logic is_blank;
		logic is_dash;
		logic is_colon;
		logic is_tsep;
		logic is_dot;
		logic is_plus;
		logic is_minus;
		logic out_busy;
	} status_t;

	// Powers of ten for fraction padding
	function automatic logic [POW10_W-1:0] pow10(input logic [3:0] n);
		logic [POW10_W-1:0] r;
		case (n)
			4'd0:    r = 30'd1;
			4'd1:    r = 30'd10;
			4'd2:    r = 30'd100;
			4'd3:    r = 30'd1000;
			4'd4:    r = 30'd10000;
			4'd5:    r = 30'd100000;
			4'd6:    r = 30'd1000000;
			4'd7:    r = 30'd10000000;
			4'd8:    r = 30'd100000000;
			4'd9:    r = 30'd1000000000;
			default: r = '0;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

[rtl/tse_ctrl.sv]
`default_nettype none

module tse_ctrl import tse_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	input  logic    in_last,
	output logic    in_ready,
	input  status_t status,
	output cmd_t    cmd
);

	// Positions inside YYYY-MM-DDTHH:MM:SS
	localparam logic [POS_W-1:0] POS_DASH1  = 5'd4;
	localparam logic [POS_W-1:0] POS_DASH2  = 5'd7;
	localparam logic [POS_W-1:0] POS_TSEP   = 5'd10;
	localparam logic [POS_W-1:0] POS_COLON1 = 5'd13;
	localparam logic [POS_W-1:0] POS_COLON2 = 5'd16;
	localparam logic [POS_W-1:0] POS_LAST   = 5'd18;

	state_t           state_q, state_d;
	logic [POS_W-1:0] pos_q, pos_d;
	out_kind_t        kind_q, kind_d;

	logic             accept;
	logic [POS_W-1:0] fix_pos;
	logic             fix_ok;
	acc_sel_t         fix_acc;
	state_t           p_next;
	logic [POS_W-1:0] pos_next;
	acc_sel_t         p_acc;
	logic             p_sign;
	out_kind_t        p_kind;

	assign accept  = in_valid && in_ready;
	assign fix_pos = (state_q == ST_FIXED) ? pos_q : '0;

	// Decode one character of the fixed part
	always_comb begin
		fix_acc = ACC_NONE;
		case (fix_pos)
			POS_DASH1, POS_DASH2:   fix_ok = status.is_dash;
			POS_TSEP:               fix_ok = status.is_tsep;
			POS_COLON1, POS_COLON2: fix_ok = status.is_colon;
			default: begin
				fix_ok = status.is_digit;
				if (fix_pos < POS_DASH1)
					fix_acc = ACC_YEAR;
				else if (fix_pos < POS_DASH2)
					fix_acc = ACC_MONTH;
				else if (fix_pos < POS_TSEP)
					fix_acc = ACC_DAY;
				else if (fix_pos < POS_COLON1)
					fix_acc = ACC_HOUR;
				else if (fix_pos < POS_COLON2)
					fix_acc = ACC_MIN;
				else
					fix_acc = ACC_SEC;
			end
		endcase
	end

	// Parse step: phase after this character and what it feeds
	always_comb begin
		p_next   = state_q;
		pos_next = pos_q;
		p_acc    = ACC_NONE;
		p_sign   = 1'b0;
		case (state_q)
			ST_START, ST_FIXED: begin
				if (state_q == ST_FIXED || !status.is_blank) begin
					if (fix_ok) begin
						p_next   = (fix_pos == POS_LAST) ? ST_AFTER_SEC : ST_FIXED;
						pos_next = fix_pos + 5'd1;
						p_acc    = fix_acc;
					end else begin
						p_next = ST_ERR_DT;
					end
				end
			end
			ST_AFTER_SEC, ST_FRAC: begin
				if (state_q == ST_AFTER_SEC && status.is_dot) begin
					p_next = ST_FRAC;
				end else if (state_q == ST_FRAC && status.is_digit) begin
					p_acc = ACC_FRAC;
				end else if (status.is_plus || status.is_minus) begin
					p_next = ST_OFF_H1;
					p_sign = 1'b1;
				end else begin
					p_next = ST_DONE;
				end
			end
			ST_OFF_H1, ST_OFF_H2: begin
				if (status.is_digit) begin
					p_acc  = ACC_OFF_H;
					p_next = (state_q == ST_OFF_H1) ? ST_OFF_H2 : ST_OFF_COLON;
				end else begin
					p_next = ST_ERR_OFF;
				end
			end
			ST_OFF_COLON: begin
				p_next = status.is_colon ? ST_OFF_M1 : ST_ERR_OFF;
			end
			ST_OFF_M1, ST_OFF_M2: begin
				if (status.is_digit) begin
					p_acc  = ACC_OFF_M;
					p_next = (state_q == ST_OFF_M1) ? ST_OFF_M2 : ST_DONE;
				end else begin
					p_next = ST_ERR_OFF;
				end
			end
			default: ;
		endcase
	end

	// Classify the text once its last character is in
	always_comb begin
		case (p_next)
			ST_START:                        p_kind = OUT_BLANK;
			ST_FIXED, ST_ERR_DT:             p_kind = OUT_ERR_DT;
			ST_OFF_H1, ST_OFF_H2, ST_OFF_COLON,
			ST_OFF_M1, ST_OFF_M2, ST_ERR_OFF: p_kind = OUT_ERR_OFF;
			default:                         p_kind = OUT_EPOCH;
		endcase
	end

	// Next state
	always_comb begin
		state_d = state_q;
		pos_d   = pos_q;
		kind_d  = kind_q;
		case (state_q)
			ST_CV1: state_d = ST_CV2;
			ST_CV2: state_d = ST_CV3;
			ST_CV3: state_d = ST_CV4;
			ST_CV4: state_d = ST_CV5;
			ST_CV5: state_d = ST_CV6;
			ST_CV6: state_d = ST_CV7;
			ST_CV7: state_d = ST_EMIT;
			ST_EMIT: begin
				if (!status.out_busy) begin
					state_d = ST_START;
					pos_d   = '0;
				end
			end
			default: begin
				if (accept) begin
					pos_d = pos_next;
					if (in_last) begin
						kind_d  = p_kind;
						state_d = (p_kind == OUT_EPOCH) ? ST_CV1 : ST_EMIT;
					end else begin
						state_d = p_next;
					end
				end
			end
		endcase
	end

	// Outputs
	always_comb begin
		in_ready     = 1'b1;
		cmd.acc_sel  = ACC_NONE;
		cmd.set_sign = 1'b0;
		cmd.sign_neg = status.is_minus;
		cmd.clear    = 1'b0;
		cmd.cv_step  = CV_IDLE;
		cmd.load_out = 1'b0;
		cmd.out_kind = kind_q;
		case (state_q)
			ST_CV1: begin in_ready = 1'b0; cmd.cv_step = CV_1; end
			ST_CV2: begin in_ready = 1'b0; cmd.cv_step = CV_2; end
			ST_CV3: begin in_ready = 1'b0; cmd.cv_step = CV_3; end
			ST_CV4: begin in_ready = 1'b0; cmd.cv_step = CV_4; end
			ST_CV5: begin in_ready = 1'b0; cmd.cv_step = CV_5; end
			ST_CV6: begin in_ready = 1'b0; cmd.cv_step = CV_6; end
			ST_CV7: begin in_ready = 1'b0; cmd.cv_step = CV_7; end
			ST_EMIT: begin
				in_ready     = 1'b0;
				cmd.load_out = !status.out_busy;
				cmd.clear    = !status.out_busy;
			end
			default: begin
				cmd.acc_sel  = accept ? p_acc : ACC_NONE;
				cmd.set_sign = accept && p_sign;
			end
		endcase
	end

	// State registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_START;
			pos_q   <= '0;
			kind_q  <= OUT_EPOCH;
		end else begin
			state_q <= state_d;
			pos_q   <= pos_d;
			kind_q  <= kind_d;
		end
	end

endmodule

`default_nettype wire

[rtl/tse_dpath.sv]
`default_nettype none

module tse_dpath import tse_pkg::*; #(
	parameter int unsigned FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [CHAR_W-1:0]   char_in,
	input  cmd_t                cmd,
	output status_t             status,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [EPOCH_W-1:0]  epoch_micros,
	output logic [ERR_W-1:0]    parse_error,
	output logic                was_blank
);

	localparam int unsigned TAKEN_W = $clog2(FRACTION_DIGITS + 1);
	localparam int unsigned FRAC_W  = $clog2(10**FRACTION_DIGITS);
	localparam int unsigned SCALE_W = $clog2(10**FRACTION_DIGITS + 1);
	localparam logic [SCALE_W-1:0] SCALE_V = SCALE_W'(10**FRACTION_DIGITS);
	localparam logic [TAKEN_W-1:0] TAKEN_MAX = TAKEN_W'(FRACTION_DIGITS);

	// Parse accumulators
	logic [YEAR_W-1:0]  year_q;
	logic [FIELD_W-1:0] month_q, day_q, hour_q, minute_q, second_q;
	logic [FIELD_W-1:0] off_h_q, off_m_q;
	logic [FRAC_W-1:0]  frac_q;
	logic [TAKEN_W-1:0] taken_q;
	logic               off_neg_q;

	// Conversion registers
	logic signed [14:0] yadj_q;
	logic signed [5:0]  era_q;
	logic [14:0]        doynum_q;
	logic [18:0]        tod_q, offv_q;
	logic [8:0]         yoe_q;
	logic signed [12:0] doy_q;
	logic [FRAC_W-1:0]  frac_s_q;
	logic signed [20:0] tsec_q;
	logic signed [18:0] doe_q;
	logic signed [23:0] days_q;
	logic signed [47:0] secs_q;
	logic [63:0]        plo_q;
	logic [31:0]        phi_q;

	// Output register
	logic               out_valid_q;
	logic [EPOCH_W-1:0] epoch_q;
	logic [ERR_W-1:0]   err_q;
	logic               blank_q;

	logic [3:0]         digit;
	logic               m_le2;
	logic signed [14:0] yadj_c;
	logic [26:0]        era_prod;
	logic signed [5:0]  era_c;
	logic [FIELD_W-1:0] mshift;
	logic [28:0]        q5_prod;
	logic signed [15:0] yoe_w;
	logic [1:0]         d100;
	logic [31:0]        secs_hi;

	// Character classes
	assign digit           = 4'(char_in - CH_0);
	assign status.is_digit = (char_in >= CH_0) && (char_in <= CH_9);
	assign status.is_blank = (char_in == CH_SPACE) || (char_in == CH_TAB) ||
	                         (char_in == CH_CR) || (char_in == CH_LF);
	assign status.is_dash  = (char_in == CH_DASH);
	assign status.is_colon = (char_in == CH_COLON);
	assign status.is_tsep  = (char_in == CH_T_UP) || (char_in == CH_T_LO) ||
	                         (char_in == CH_SPACE);
	assign status.is_dot   = (char_in == CH_DOT);
	assign status.is_plus  = (char_in == CH_PLUS);
	assign status.is_minus = (char_in == CH_DASH);
	assign status.out_busy = out_valid_q && !out_ready;

	// Shift digits into the accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			off_h_q   <= '0;
			off_m_q   <= '0;
			frac_q    <= '0;
			taken_q   <= '0;
			off_neg_q <= 1'b0;
		end else if (cmd.clear) begin
			year_q    <= '0;
			month_q   <= '0;
			day_q     <= '0;
			hour_q    <= '0;
			minute_q  <= '0;
			second_q  <= '0;
			off_h_q   <= '0;
			off_m_q   <= '0;
			frac_q    <= '0;
			taken_q   <= '0;
			off_neg_q <= 1'b0;
		end else begin
			case (cmd.acc_sel)
				ACC_YEAR:  year_q   <= year_q * YEAR_W'(10) + YEAR_W'(digit);
				ACC_MONTH: month_q  <= month_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_DAY:   day_q    <= day_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_HOUR:  hour_q   <= hour_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_MIN:   minute_q <= minute_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_SEC:   second_q <= second_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_OFF_H: off_h_q  <= off_h_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_OFF_M: off_m_q  <= off_m_q * FIELD_W'(10) + FIELD_W'(digit);
				ACC_FRAC: begin
					// Drop digits beyond the kept precision
					if (taken_q < TAKEN_MAX) begin
						frac_q  <= frac_q * FRAC_W'(10) + FRAC_W'(digit);
						taken_q <= taken_q + TAKEN_W'(1);
					end
				end
				default: ;
			endcase
			if (cmd.set_sign)
				off_neg_q <= cmd.sign_neg;
		end
	end

	// Step 1: shifted year, era, month index, time of day, offset
	assign m_le2    = (month_q <= FIELD_W'(2));
	assign yadj_c   = $signed(15'(year_q)) - $signed(15'(m_le2));
	assign era_prod = 27'(yadj_c[13:0]) * 27'd5243;
	assign era_c    = yadj_c[14] ? -6'sd1 : $signed(6'(era_prod >> 21));
	assign mshift   = m_le2 ? (month_q + FIELD_W'(9)) : (month_q - FIELD_W'(3));

	// Step 2 helpers: year of era, day of year by five
	assign yoe_w   = 16'(yadj_q) - 16'(era_q) * 16'sd400;
	assign q5_prod = 29'(doynum_q) * 29'd13108;

	// Step 3 helper: year of era over a hundred
	assign d100 = 2'(yoe_q >= 9'd100) + 2'(yoe_q >= 9'd200) + 2'(yoe_q >= 9'd300);

	// Step 7 helper: upper word of the sign-extended seconds
	assign secs_hi = {{16{secs_q[47]}}, secs_q[47:32]};

	// Conversion sequence, one step per cycle
	always_ff @(posedge clk) begin
		case (cmd.cv_step)
			CV_1: begin
				yadj_q   <= yadj_c;
				era_q    <= era_c;
				doynum_q <= 15'(mshift) * 15'd153 + 15'd2;
				tod_q    <= 19'(hour_q) * 19'd3600 + 19'(minute_q) * 19'd60 + 19'(second_q);
				offv_q   <= 19'(off_h_q) * 19'd3600 + 19'(off_m_q) * 19'd60;
			end
			CV_2: begin
				yoe_q    <= yoe_w[8:0];
				doy_q    <= $signed(13'(q5_prod >> 16)) + $signed(13'(day_q)) - 13'sd1;
				frac_s_q <= FRAC_W'(frac_q * pow10(4'(TAKEN_MAX - taken_q)));
				// Subtract the offset: a negative offset adds
				tsec_q   <= off_neg_q ? ($signed(21'(tod_q)) + $signed(21'(offv_q)))
				                      : ($signed(21'(tod_q)) - $signed(21'(offv_q)));
			end
			CV_3: begin
				doe_q <= $signed(19'(yoe_q) * 19'd365 + 19'(yoe_q >> 2) - 19'(d100))
				         + 19'(doy_q);
			end
			CV_4: begin
				days_q <= 24'(era_q) * 24'sd146097 + 24'(doe_q) - 24'sd719468;
			end
			CV_5: begin
				secs_q <= 48'(days_q) * 48'sd86400 + 48'(tsec_q);
			end
			CV_6: begin
				plo_q <= 64'(secs_q[31:0]) * 64'(SCALE_V);
			end
			CV_7: begin
				phi_q <= 32'(secs_hi * 32'(SCALE_V));
			end
			default: ;
		endcase
	end

	// Output register: load the result, hold until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.load_out)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.load_out) begin
			case (cmd.out_kind)
				OUT_EPOCH: begin
					epoch_q <= plo_q + {phi_q, 32'b0} + 64'(frac_s_q);
					err_q   <= ERR_NONE;
					blank_q <= 1'b0;
				end
				OUT_BLANK: begin
					epoch_q <= '0;
					err_q   <= ERR_NONE;
					blank_q <= 1'b1;
				end
				OUT_ERR_DT: begin
					epoch_q <= '0;
					err_q   <= ERR_DATE_TIME;
					blank_q <= 1'b0;
				end
				default: begin
					epoch_q <= '0;
					err_q   <= ERR_OFFSET;
					blank_q <= 1'b0;
				end
			endcase
		end
	end

	assign out_valid    = out_valid_q;
	assign epoch_micros = epoch_q;
	assign parse_error  = err_q;
	assign was_blank    = blank_q;

endmodule

`default_nettype wire

[rtl/timestamp_text_to_epoch_micros.sv]
`default_nettype none

// Channel   Dir  Bits  Contents
// s_axis    in   8+1   tdata: char_in; tlast: last_char
// m_axis    out  72    tdata: epoch_micros, parse_error, was_blank
//
// After the last character the datapath runs a seven-step conversion sequence (one
// multiplier stage per step) and one output load; a blank or malformed text skips
// the conversion and goes straight to the load. Input is held off during the
// conversion and the load. The load also waits while the output register is full.
// Reset is asynchronous and returns the parser to skipping leading whitespace.
module timestamp_text_to_epoch_micros import tse_pkg::*; #(
	parameter int unsigned FRACTION_DIGITS = FRAC_DIGITS_DEF
) (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   s_axis_tvalid,
	output logic                   s_axis_tready,
	input  logic [CHAR_W-1:0]      s_axis_tdata,  // [7:0] char_in
	input  logic                   s_axis_tlast,
	output logic                   m_axis_tvalid,
	input  logic                   m_axis_tready,
	output logic [OUT_TDATA_W-1:0] m_axis_tdata   // [63:0] epoch_micros,
	                                              // [65:64] parse_error,
	                                              // [66] was_blank
);

	cmd_t               cmd;
	status_t            status;
	logic [EPOCH_W-1:0] epoch_micros;
	logic [ERR_W-1:0]   parse_error;
	logic               was_blank;

	tse_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_axis_tvalid),
		.in_last  (s_axis_tlast),
		.in_ready (s_axis_tready),
		.status   (status),
		.cmd      (cmd)
	);

	tse_dpath #(
		.FRACTION_DIGITS (FRACTION_DIGITS)
	) u_dpath (
		.clk          (clk),
		.arst_n       (arst_n),
		.char_in      (s_axis_tdata),
		.cmd          (cmd),
		.status       (status),
		.out_valid    (m_axis_tvalid),
		.out_ready    (m_axis_tready),
		.epoch_micros (epoch_micros),
		.parse_error  (parse_error),
		.was_blank    (was_blank)
	);

	// Pack the result fields, zero pad to whole bytes
	assign m_axis_tdata = {
		(OUT_TDATA_W - EPOCH_W - ERR_W - 1)'(0), was_blank, parse_error, epoch_micros
	};

endmodule

`default_nettype wire
